/* rtl/core/stt_pkg.sv */
package stt_pkg;

  localparam int unsigned NumTimersDefault   = 16;
  localparam int unsigned MaxMultipleDefault = 4;
  localparam int unsigned MaxResults         = 16;
  localparam logic [7:0]  LeadMsReset        = 8'd10;

  localparam logic [2:0] KIND_TICK     = 3'd0;
  localparam logic [2:0] KIND_ONESHOT  = 3'd1;
  localparam logic [2:0] KIND_PERIODIC = 3'd2;
  localparam logic [2:0] KIND_REMOVE   = 3'd3;
  localparam logic [2:0] KIND_COUNT    = 3'd4;
  localparam logic [2:0] KIND_NOP      = 3'd7;

  localparam logic [1:0] SLOT_EMPTY    = 2'd0;
  localparam logic [1:0] SLOT_ONCE     = 2'd1;
  localparam logic [1:0] SLOT_PERIODIC = 2'd2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  group_tag;
    logic [19:0] delay_ms;
    logic        allow_align;
    logic [15:0] match_event;
    logic        any_event;
    logic        any_group;
  } cmd_t;

  typedef struct packed {
    logic        fired;
    logic [15:0] timer_id;
    logic [7:0]  event_group;
    logic        status;
    logic [4:0]  match_count;
    logic        last;
  } res_t;

endpackage

/* rtl/core/stt_front.sv */
module stt_front
  import stt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  cmd_t  cmd_in,
  output logic  q_valid,
  input  logic  q_take,
  output cmd_t  q_cmd
);

  // Two-entry queue of commands; unknown kinds are mapped onto a no-op code here.
  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  cmd_t       cls;

  always_comb begin
    cls = cmd_in;
    if (cmd_in.kind > KIND_COUNT) begin
      cls.kind = KIND_NOP;
    end
  end

  assign full    = fill[1];
  assign q_valid = fill != 2'd0;
  assign q_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= cls;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_take && q_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push && !full} - {1'b0, q_take && q_valid};
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= 2'd2)
    else $error("command queue overfilled");
  a_full_valid: assert property (@(posedge clk) disable iff (rst)
    full |-> q_valid)
    else $error("queue full but nothing offered");
  a_take_valid: assert property (@(posedge clk) disable iff (rst)
    q_take |-> q_valid)
    else $error("command taken from an empty queue");

endmodule

/* rtl/core/stt_back.sv */
module stt_back
  import stt_pkg::*;
#(
  parameter int unsigned NUM_TIMERS   = NumTimersDefault,
  parameter int unsigned MAX_MULTIPLE = MaxMultipleDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] lead_ms,
  input  logic       q_valid,
  output logic       q_take,
  input  cmd_t       q_cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output res_t       res
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned MW = $clog2(MAX_MULTIPLE + 1) + 1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_FIRE   = 4'd2;
  localparam logic [3:0] S_ALIGN  = 4'd3;
  localparam logic [3:0] S_MULT   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_PLACE  = 4'd6;
  localparam logic [3:0] S_MATCH  = 4'd7;
  localparam logic [3:0] S_EMIT   = 4'd8;
  localparam logic [3:0] S_FINAL  = 4'd9;
  localparam logic [3:0] S_SCORE  = 4'd10;
  localparam logic [3:0] S_DIVMUL = 4'd11;

  logic [1:0]  slot_kind   [NUM_TIMERS];
  logic [15:0] slot_event  [NUM_TIMERS];
  logic [7:0]  slot_group  [NUM_TIMERS];
  logic [19:0] slot_period [NUM_TIMERS];
  logic [31:0] slot_expire [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] slot_done;

  logic [31:0] now_ms;
  logic [15:0] id_counter;
  logic [3:0]  state;
  cmd_t        cur;
  logic [IW-1:0] idx;
  logic          idx_end;
  logic [4:0]  n_fired;
  logic [4:0]  cnt;
  logic        best_ok;
  logic [IW-1:0] best;
  logic [31:0] best_exp;
  logic [32:0] limit;
  logic [IW-1:0] free_slot;
  logic        free_ok;
  logic [36:0] align_score;
  logic [MW-1:0] mul_i;
  logic [19:0] ref_per;
  logic [39:0] prod;
  logic [31:0] quot;
  logic [31:0] rem;
  logic [5:0]  div_cnt;
  logic        ref_later;
  logic [31:0] ref_exp;
  logic [51:0] mprod;

  assign idx_end = ({1'b0, idx} == (IW + 1)'(NUM_TIMERS - 1));
  assign q_take  = (state == S_IDLE) && q_valid && !res_valid;

  function automatic logic [4:0] sat_inc(input logic [4:0] v);
    return (v == 5'd31) ? v : v + 5'd1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      now_ms     <= 32'd0;
      id_counter <= 16'd0;
      n_fired    <= 5'd0;
      slot_done  <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        slot_kind[i] <= SLOT_EMPTY;
      end
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_take) begin
            cur     <= q_cmd;
            idx     <= '0;
            n_fired <= 5'd0;
            cnt     <= 5'd0;
            best_ok <= 1'b0;
            free_ok <= 1'b0;
            res     <= '0;
            case (q_cmd.kind)
              KIND_TICK: begin
                now_ms <= now_ms + 32'd1;
                limit  <= {1'b0, now_ms + 32'd1} + {25'd0, lead_ms};
                for (int i = 0; i < NUM_TIMERS; i++) begin
                  if (slot_kind[i] != SLOT_EMPTY) begin
                    slot_done[i] <= 1'b0;
                  end
                end
                state <= S_SCAN;
              end
              KIND_ONESHOT, KIND_PERIODIC: state <= S_ALIGN;
              KIND_REMOVE, KIND_COUNT:     state <= S_MATCH;
              default: begin
                res.last  <= 1'b1;
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        // One slot per cycle: find the earliest due timer not yet fired.
        S_SCAN: begin
          if (slot_kind[idx] != SLOT_EMPTY && !slot_done[idx] &&
              {1'b0, slot_expire[idx]} <= limit &&
              (!best_ok || slot_expire[idx] < best_exp)) begin
            best_ok  <= 1'b1;
            best     <= idx;
            best_exp <= slot_expire[idx];
          end
          if (idx_end) begin
            state <= S_FIRE;
          end
          idx <= idx + 1'b1;
        end
        S_FIRE: begin
          if (!res_valid) begin
            if (!best_ok) begin
              res       <= '0;
              res.last  <= (n_fired == 5'd0);
              res_valid <= (n_fired == 5'd0);
              state     <= S_IDLE;
            end else begin
              slot_done[best] <= 1'b1;
              if (slot_kind[best] == SLOT_ONCE) begin
                slot_kind[best] <= SLOT_EMPTY;
              end else begin
                slot_expire[best] <= slot_expire[best] + {12'd0, slot_period[best]};
              end
              res             <= '0;
              res.fired       <= 1'b1;
              res.timer_id    <= slot_event[best];
              res.event_group <= slot_group[best];
              n_fired         <= n_fired + 5'd1;
              best_ok         <= 1'b0;
              idx             <= '0;
              state           <= S_EMIT;
            end
          end
        end
        // Holds a fired result until a later scan decides whether it is the last.
        S_EMIT: begin
          if (n_fired == 5'(MaxResults)) begin
            res.last  <= 1'b1;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end else begin
            state <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (slot_kind[idx] != SLOT_EMPTY && !slot_done[idx] &&
              {1'b0, slot_expire[idx]} <= limit &&
              (!best_ok || slot_expire[idx] < best_exp)) begin
            best_ok  <= 1'b1;
            best     <= idx;
            best_exp <= slot_expire[idx];
          end
          idx <= idx + 1'b1;
          if (idx_end) begin
            res.last  <= !(best_ok || (slot_kind[idx] != SLOT_EMPTY &&
                          !slot_done[idx] && {1'b0, slot_expire[idx]} <= limit));
            res_valid <= 1'b1;
            state     <= S_FIRE;
          end
        end
        // Lowest free slot, and the start of the alignment search.
        S_ALIGN: begin
          if (!free_ok && slot_kind[idx] == SLOT_EMPTY) begin
            free_ok   <= 1'b1;
            free_slot <= idx;
          end
          idx <= idx + 1'b1;
          if (idx_end) begin
            idx         <= '0;
            align_score <= '0;
            if (!free_ok && slot_kind[idx] != SLOT_EMPTY) begin
              res.status <= 1'b1;
              res.last   <= 1'b1;
              res_valid  <= 1'b1;
              state      <= S_IDLE;
            end else if (cur.kind == KIND_PERIODIC && cur.allow_align &&
                         cur.delay_ms != 20'd0) begin
              state <= S_SCORE;
              mul_i <= '0;
            end else begin
              ref_exp <= now_ms + {12'd0, cur.delay_ms};
              state   <= S_PLACE;
            end
          end
        end
        // Overlap score for slot idx, one multiple at a time, each through a division in S_DIV.
        S_SCORE: begin
          if (slot_kind[idx] != SLOT_PERIODIC || slot_period[idx] == 20'd0 ||
              mul_i == MW'(MAX_MULTIPLE)) begin
            mul_i <= '0;
            idx   <= idx + 1'b1;
            if (idx_end) begin
              state <= S_MULT;
            end
          end else if (slot_period[idx] == cur.delay_ms) begin
            best_ok <= 1'b1;
            best    <= idx;
            state   <= S_MULT;
          end else begin
            ref_per <= slot_period[idx];
            if (slot_period[idx] > cur.delay_ms) begin
              prod <= 40'(slot_period[idx]) * 40'(mul_i + 1'b1);
            end else begin
              prod <= 40'(cur.delay_ms) * 40'(mul_i + 1'b1);
            end
            quot     <= '0;
            rem      <= '0;
            div_cnt  <= 6'd0;
            state    <= S_DIV;
          end
        end
        // Restoring division of prod (low 32 bits, which hold the whole product) by the smaller period.
        S_DIV: begin
          if (div_cnt == 6'd32) begin
            if (rem == 32'd0) begin
              if ((ref_per > cur.delay_ms ? {5'd0, quot} : 37'(mul_i + 1'b1)) <
                  align_score || !best_ok) begin
                best_ok     <= 1'b1;
                best        <= idx;
                align_score <= ref_per > cur.delay_ms ? {5'd0, quot} : 37'(mul_i + 1'b1);
              end
              mul_i <= '0;
              idx   <= idx + 1'b1;
              state <= idx_end ? S_MULT : S_SCORE;
            end else begin
              mul_i <= mul_i + 1'b1;
              state <= S_SCORE;
            end
          end else begin
            if ({rem[30:0], prod[31 - div_cnt[4:0]]} >=
                (ref_per > cur.delay_ms ? {12'd0, cur.delay_ms} : {12'd0, ref_per})) begin
              rem  <= {rem[30:0], prod[31 - div_cnt[4:0]]} -
                      (ref_per > cur.delay_ms ? {12'd0, cur.delay_ms} : {12'd0, ref_per});
              quot <= {quot[30:0], 1'b1};
            end else begin
              rem  <= {rem[30:0], prod[31 - div_cnt[4:0]]};
              quot <= {quot[30:0], 1'b0};
            end
            div_cnt <= div_cnt + 6'd1;
          end
        end
        // Phase from the reference timer, if any: divide the distance by the period; else plain delay.
        S_MULT: begin
          if (!best_ok) begin
            ref_exp <= now_ms + {12'd0, cur.delay_ms};
            state   <= S_PLACE;
          end else begin
            ref_exp     <= slot_expire[best];
            ref_later   <= slot_expire[best] > now_ms;
            prod        <= {8'd0, (slot_expire[best] > now_ms) ?
                            slot_expire[best] - now_ms : now_ms - slot_expire[best]};
            quot        <= '0;
            rem         <= '0;
            div_cnt     <= 6'd0;
            ref_per     <= cur.delay_ms;
            align_score <= 37'd0;
            state       <= S_DIVMUL;
          end
        end
        S_DIVMUL: begin
          if (div_cnt == 6'd32) begin
            mprod   <= {20'd0, ref_later ? quot : quot + 32'd1} * 52'(cur.delay_ms);
            div_cnt <= 6'd33;
          end else if (div_cnt == 6'd33) begin
            ref_exp <= ref_later ? ref_exp - mprod[31:0] : ref_exp + mprod[31:0];
            state   <= S_PLACE;
          end else begin
            if ({rem[30:0], prod[31 - div_cnt[4:0]]} >= {12'd0, ref_per}) begin
              rem  <= {rem[30:0], prod[31 - div_cnt[4:0]]} - {12'd0, ref_per};
              quot <= {quot[30:0], 1'b1};
            end else begin
              rem  <= {rem[30:0], prod[31 - div_cnt[4:0]]};
              quot <= {quot[30:0], 1'b0};
            end
            div_cnt <= div_cnt + 6'd1;
          end
        end
        S_PLACE: begin
          id_counter               <= id_counter + 16'd1;
          slot_kind[free_slot]     <= (cur.kind == KIND_PERIODIC) ? SLOT_PERIODIC : SLOT_ONCE;
          slot_event[free_slot]    <= id_counter + 16'd1;
          slot_group[free_slot]    <= cur.group_tag;
          slot_period[free_slot]   <= cur.delay_ms;
          slot_expire[free_slot]   <= ref_exp;
          slot_done[free_slot]     <= 1'b1;
          res.timer_id             <= id_counter + 16'd1;
          res.last                 <= 1'b1;
          res_valid                <= 1'b1;
          state                    <= S_IDLE;
        end
        S_MATCH: begin
          if (slot_kind[idx] != SLOT_EMPTY &&
              (cur.any_event || slot_event[idx] == cur.match_event) &&
              (cur.any_group || slot_group[idx] == cur.group_tag)) begin
            cnt <= sat_inc(cnt);
            if (cur.kind == KIND_REMOVE) begin
              slot_kind[idx] <= SLOT_EMPTY;
            end
          end
          idx <= idx + 1'b1;
          if (idx_end) begin
            res.match_count <= (slot_kind[idx] != SLOT_EMPTY &&
                (cur.any_event || slot_event[idx] == cur.match_event) &&
                (cur.any_group || slot_group[idx] == cur.group_tag)) ? sat_inc(cnt) : cnt;
            res.last  <= 1'b1;
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fire_not_idle: assert property (@(posedge clk) disable iff (rst)
    q_take |-> !res_valid)
    else $error("command taken while a result waits");
  a_fire_count: assert property (@(posedge clk) disable iff (rst)
    n_fired <= 5'(MaxResults))
    else $error("too many firings in one tick");
  a_res_held: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("result dropped before transfer");

endmodule

/* rtl/core/software_timer_table.sv */
// A tick scans the whole table, then rescans it after each fired timer to find the
// next one and whether the result is the last, plus any wait on pop; remove and count
// scan the table once; schedule scans it for a free slot, and with alignment runs a
// division for each multiple tried for each slot, plus one more for the phase.
// Throughput: one command at a time in the back end; a two-entry queue in front.
// Reset (rst, synchronous): table empty, time and id counter zero, lead_ms 10.
module software_timer_table
  import stt_pkg::*;
#(
  parameter int unsigned NUM_TIMERS   = NumTimersDefault,
  parameter int unsigned MAX_MULTIPLE = MaxMultipleDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  kind,
  input  logic [7:0]  group_tag,
  input  logic [19:0] delay_ms,
  input  logic        allow_align,
  input  logic [15:0] match_event,
  input  logic        any_event,
  input  logic        any_group,
  output logic        empty,
  input  logic        pop,
  output logic        fired,
  output logic [15:0] timer_id,
  output logic [7:0]  event_group,
  output logic        status,
  output logic [4:0]  match_count,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0] lead_ms;
  cmd_t cmd_in;
  cmd_t q_cmd;
  logic q_valid;
  logic q_take;
  logic res_valid;
  res_t res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      lead_ms <= LeadMsReset;
    end else if (cfg_valid) begin
      lead_ms <= cfg_data;
    end
  end

  assign cmd_in = '{kind: kind, group_tag: group_tag, delay_ms: delay_ms,
                    allow_align: allow_align, match_event: match_event,
                    any_event: any_event, any_group: any_group};

  stt_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .cmd_in(cmd_in),
    .q_valid(q_valid), .q_take(q_take), .q_cmd(q_cmd)
  );

  stt_back #(.NUM_TIMERS(NUM_TIMERS), .MAX_MULTIPLE(MAX_MULTIPLE)) u_back (
    .clk(clk), .rst(rst), .lead_ms(lead_ms), .q_valid(q_valid), .q_take(q_take),
    .q_cmd(q_cmd), .res_valid(res_valid), .res_ready(pop), .res(res)
  );

  assign empty       = !res_valid;
  assign fired       = res.fired;
  assign timer_id    = res.timer_id;
  assign event_group = res.event_group;
  assign status      = res.status;
  assign match_count = res.match_count;
  assign last        = res.last;

endmodule

/* verif/software_timer_table_tb.sv */
module software_timer_table_tb;
  import stt_pkg::*;

  localparam int NT = NumTimersDefault;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic cfg_valid = 1'b0;
  logic [7:0] cfg_data = 8'd0;
  cmd_t cur = '0;
  logic full, empty, cfg_ready;
  res_t got;

  software_timer_table u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .kind(cur.kind), .group_tag(cur.group_tag), .delay_ms(cur.delay_ms),
    .allow_align(cur.allow_align), .match_event(cur.match_event),
    .any_event(cur.any_event), .any_group(cur.any_group),
    .empty(empty), .pop(pop),
    .fired(got.fired), .timer_id(got.timer_id), .event_group(got.event_group),
    .status(got.status), .match_count(got.match_count), .last(got.last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow of the timer table.
  logic [1:0]  sh_kind[NT];
  logic [15:0] sh_event[NT];
  logic [7:0]  sh_group[NT];
  logic [19:0] sh_period[NT];
  logic [31:0] sh_expire[NT];
  bit          sh_done[NT];
  logic [31:0] sh_now = '0;
  logic [15:0] sh_ids = '0;
  logic [7:0]  sh_lead = LeadMsReset;

  cmd_t pending_cmds[$];
  res_t expected_res[$];
  int errors = 0;
  int cycles = 0;
  int n_fired = 0;
  int n_full = 0;
  int n_items = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit taken = 0;
  bit cfg_hit = 0;
  bit hold_req = 0;
  int hold = 0;
  int gen_ids = 0;

  initial for (int i = 0; i < NT; i++) begin
    sh_kind[i] = SLOT_EMPTY;
    sh_done[i] = 0;
  end

  function automatic int unsigned overlap(int unsigned chk, int unsigned ex);
    if (chk == 0 || ex == 0) return 0;
    if (chk == ex) return 1;
    for (int unsigned i = 1; i <= MaxMultipleDefault; i++) begin
      if (ex > chk) begin
        if ((ex * i) % chk == 0) return (ex * i) / chk;
      end else if ((chk * i) % ex == 0) begin
        return i;
      end
    end
    return 0;
  endfunction

  function automatic res_t mk(bit f, logic [15:0] ev, logic [7:0] g, bit st,
                              logic [4:0] cnt, bit l);
    res_t r;
    r.fired = f; r.timer_id = ev; r.event_group = g;
    r.status = st; r.match_count = cnt; r.last = l;
    return r;
  endfunction

  task automatic predict_timers(cmd_t c);
    logic [32:0] lim;
    logic [31:0] ref_t, d, expire;
    int n, best, slot;
    int unsigned sc, best_sc;
    logic [4:0] cnt;
    case (c.kind)
      KIND_TICK: begin
        sh_now = sh_now + 32'd1;
        lim = {1'b0, sh_now} + {25'd0, sh_lead};
        for (int i = 0; i < NT; i++) if (sh_kind[i] != SLOT_EMPTY) sh_done[i] = 0;
        n = 0;
        while (n < MaxResults) begin
          best = -1;
          for (int i = 0; i < NT; i++)
            if (sh_kind[i] != SLOT_EMPTY && !sh_done[i] && {1'b0, sh_expire[i]} <= lim)
              if (best < 0 || sh_expire[i] < sh_expire[best]) best = i;
          if (best < 0) break;
          sh_done[best] = 1;
          if (sh_kind[best] == SLOT_ONCE) sh_kind[best] = SLOT_EMPTY;
          else sh_expire[best] = sh_expire[best] + {12'd0, sh_period[best]};
          expected_res.push_back(mk(1, sh_event[best], sh_group[best], 0, 0, 0));
          n++;
          n_fired++;
        end
        if (n == 0) expected_res.push_back(mk(0, 0, 0, 0, 0, 1));
        else expected_res[expected_res.size() - 1].last = 1;
      end
      KIND_ONESHOT, KIND_PERIODIC: begin
        slot = -1;
        best = -1;
        best_sc = 0;
        for (int i = 0; i < NT; i++)
          if (slot < 0 && sh_kind[i] == SLOT_EMPTY) slot = i;
        if (slot < 0) begin
          expected_res.push_back(mk(0, 0, 0, 1, 0, 1));
          n_full++;
        end else begin
          if (c.kind == KIND_PERIODIC && c.allow_align) begin
            for (int i = 0; i < NT; i++) begin
              if (sh_kind[i] != SLOT_PERIODIC) continue;
              sc = overlap(c.delay_ms, sh_period[i]);
              if (sc == 0) continue;
              if (sc == 1) begin
                best = i;
                break;
              end
              if (best < 0 || sc < best_sc) begin
                best = i;
                best_sc = sc;
              end
            end
          end
          if (best >= 0 && c.delay_ms != 0) begin
            ref_t = sh_expire[best];
            if (ref_t > sh_now) begin
              d = ((ref_t - sh_now) / {12'd0, c.delay_ms}) * {12'd0, c.delay_ms};
              expire = ref_t - d;
            end else begin
              d = (sh_now - ref_t) / {12'd0, c.delay_ms} + 32'd1;
              expire = ref_t + d * {12'd0, c.delay_ms};
            end
          end else begin
            expire = sh_now + {12'd0, c.delay_ms};
          end
          sh_ids = sh_ids + 16'd1;
          sh_kind[slot] = (c.kind == KIND_ONESHOT) ? SLOT_ONCE : SLOT_PERIODIC;
          sh_event[slot] = sh_ids;
          sh_group[slot] = c.group_tag;
          sh_period[slot] = c.delay_ms;
          sh_expire[slot] = expire;
          sh_done[slot] = 1;
          expected_res.push_back(mk(0, sh_ids, 0, 0, 0, 1));
        end
      end
      KIND_REMOVE, KIND_COUNT: begin
        cnt = 0;
        for (int i = 0; i < NT; i++) begin
          if (sh_kind[i] == SLOT_EMPTY) continue;
          if (!c.any_event && sh_event[i] != c.match_event) continue;
          if (!c.any_group && sh_group[i] != c.group_tag) continue;
          if (c.kind == KIND_REMOVE) sh_kind[i] = SLOT_EMPTY;
          if (cnt < 5'd31) cnt++;
        end
        expected_res.push_back(mk(0, 0, 0, 0, cnt, 1));
      end
      default: expected_res.push_back(mk(0, 0, 0, 0, 0, 1));
    endcase
  endtask

  // Sampling at the rising edge: transfers in, results out, register writes.
  always @(posedge clk) begin
    res_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end else if (!rst) begin
      if (push && !full) begin
        predict_timers(cur);
        taken = 1;
        n_items++;
      end
      if (cfg_valid && cfg_ready) begin
        sh_lead = cfg_data;
        cfg_hit = 1;
      end
      if (pop && !empty) begin
        if (expected_res.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %p", got);
        end else begin
          e = expected_res.pop_front();
          if (got.fired !== e.fired || got.timer_id !== e.timer_id ||
              got.event_group !== e.event_group || got.status !== e.status ||
              got.match_count !== e.match_count || got.last !== e.last) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p, got %p", e, got);
          end
        end
      end
    end
  end

  // Sender: keeps an offered item on the ports until it has been taken.
  always @(negedge clk) begin
    bit held;
    if (!rst) begin
      held = push && !taken;
      if (taken) begin
        void'(pending_cmds.pop_front());
        taken = 0;
      end
      if (pending_cmds.size() > 0 && (held || $urandom_range(99) >= idle_pct)) begin
        push <= 1'b1;
        cur <= pending_cmds[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver, with an optional long hold-off to back the block up.
  always @(negedge clk) begin
    if (hold_req) begin
      hold = 300;
      hold_req = 0;
    end
    if (hold > 0) begin
      hold--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic cmd_t timer_cmd(logic [2:0] k, logic [7:0] g, logic [19:0] dly,
                                     bit al, logic [15:0] ev, bit ae, bit ag);
    cmd_t c;
    c.kind = k; c.group_tag = g; c.delay_ms = dly; c.allow_align = al;
    c.match_event = ev; c.any_event = ae; c.any_group = ag;
    return c;
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    logic [63:0] raw;
    int r;
    raw = {$urandom(), $urandom()};
    c = raw[$bits(cmd_t)-1:0];
    r = $urandom_range(99);
    if (r >= 96) return c;
    c.kind = r < 35 ? KIND_TICK : r < 55 ? KIND_ONESHOT : r < 75 ? KIND_PERIODIC :
             r < 86 ? KIND_REMOVE : KIND_COUNT;
    if ($urandom_range(3) != 0) c.group_tag = 8'($urandom_range(3));
    r = $urandom_range(99);
    if (r < 80) c.delay_ms = 20'($urandom_range(30));
    else if (r < 95) c.delay_ms = 20'($urandom_range(1000));
    if ($urandom_range(9) < 7) c.match_event = 16'(gen_ids - $urandom_range(5));
    c.any_event = ($urandom_range(9) < 3);
    c.any_group = ($urandom_range(9) < 3);
    if (c.kind == KIND_ONESHOT || c.kind == KIND_PERIODIC) gen_ids++;
    return c;
  endfunction

  task automatic write_lead(logic [7:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(negedge clk); while (!cfg_hit);
    cfg_valid = 1'b0;
    cfg_hit = 0;
  endtask

  task automatic run_phase(int idle, int stall, int n, bit pressure);
    idle_pct = idle;
    stall_pct = stall;
    if (pressure) hold_req = 1;
    for (int i = 0; i < n; i++) pending_cmds.push_back(random_cmd());
    wait (pending_cmds.size() == 0 && !push);
    wait (expected_res.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    // Directed: zero delay, alignment, matching, unknown kinds, then a full table.
    pending_cmds.push_back(timer_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_PERIODIC, 8'hFF, 0, 1, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_PERIODIC, 1, 8, 0, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_PERIODIC, 1, 16, 1, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_PERIODIC, 2, 12, 1, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_PERIODIC, 2, 8, 1, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_ONESHOT, 0, 20'hFFFFF, 1, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_COUNT, 0, 0, 0, 0, 1, 1));
    pending_cmds.push_back(timer_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_COUNT, 1, 0, 0, 0, 1, 0));
    pending_cmds.push_back(timer_cmd(KIND_REMOVE, 8'hFF, 0, 0, 16'd1, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_COUNT, 0, 0, 0, 16'hFFFF, 0, 1));
    pending_cmds.push_back(timer_cmd(3'd5, 8'hFF, 20'hFFFFF, 1, 16'hFFFF, 1, 1));
    pending_cmds.push_back(timer_cmd(3'd6, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(3'd7, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 12; i++)
      pending_cmds.push_back(timer_cmd(KIND_ONESHOT, 8'(i), 3, 0, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_ONESHOT, 9, 3, 0, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_TICK, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(timer_cmd(KIND_REMOVE, 0, 0, 0, 0, 1, 1));
    gen_ids = 17;
    run_phase(0, 0, 30, 0);
    write_lead(8'd0);
    run_phase(60, 0, 30, 1);
    write_lead(8'd255);
    run_phase(0, 60, 30, 0);
    write_lead(8'($urandom_range(1, 254)));
    run_phase(13, 13, 30, 0);
    $display("%0d items sent over four idling phases and lead windows 10, 0, 255, random;",
             n_items);
    $display("%0d timer expiries and %0d table-full schedules predicted, %0d mismatches.",
             n_fired, n_full, errors);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
